/* src/mhpq_pkg.sv */
// Shared types and constants for the max heap priority queue.
package mhpq_pkg;

  localparam int DEF_CAPACITY  = 128;
  localparam int DEF_KEY_WIDTH = 32;

  localparam int FIELD_KEY_W   = 32;
  localparam int FIELD_CNT_W   = 8;
  localparam int FIELD_LIMIT_W = 8;

  localparam logic [FIELD_LIMIT_W-1:0] LIMIT_RESET = 8'd128;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic                          func;
    logic signed [FIELD_KEY_W-1:0] key_in;
  } cmd_t;

  typedef struct packed {
    logic [1:0]                    status;
    logic signed [FIELD_KEY_W-1:0] key_out;
    logic [FIELD_CNT_W-1:0]        count;
  } res_t;

endpackage

/* src/max_heap_priority_queue.sv */
// Binary max heap priority queue with a sequenced key store (one read port, one write port).
//
//   channel   signals                  direction  beat taken when
//   -------   -----------------------  ---------  ------------------------
//   command   start, busy, cmd         in         start high, busy low
//   result    done, res                out        done high (one cycle)
//   config    cfg_we, cfg_data         in         cfg_we high
//
// Each command beat produces exactly one result beat. A refused command
// (insert into a full heap, remove from an empty one) reports on the next
// cycle. An insert climbs a level by reading the parent, then comparing
// and writing; a remove reads the root, then the last key, and sinks a
// level by reading the children, picking the larger and comparing it to
// the sunk key. Each ends by writing the moving key into its slot. All of
// it is paced by the one key memory, which gives one read and one write
// per cycle, and by the one shared key comparator. Reset is synchronous
// and clears the key count, the size limit (to 128) and the sequencer;
// the key memory is not cleared, since only positions up to the count
// are ever read. The receiver cannot stall: a result is on res for the
// single cycle that done is high, and the block is idle in that cycle.
module max_heap_priority_queue #(
  parameter int CAPACITY  = mhpq_pkg::DEF_CAPACITY,
  parameter int KEY_WIDTH = mhpq_pkg::DEF_KEY_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  mhpq_pkg::cmd_t                      cmd,
  output logic                                done,
  output mhpq_pkg::res_t                      res,
  input  logic                                cfg_we,
  input  logic [mhpq_pkg::FIELD_LIMIT_W-1:0]  cfg_data
);
  import mhpq_pkg::*;

  // Positions 1..CAPACITY are used; entry 0 is never touched.
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int LW   = (CW > FIELD_LIMIT_W) ? CW : FIELD_LIMIT_W;
  localparam int EXTW = (KEY_WIDTH > FIELD_KEY_W) ? KEY_WIDTH : FIELD_KEY_W;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_UP_RD   = 4'd1;
  localparam logic [3:0] S_UP_CMP  = 4'd2;
  localparam logic [3:0] S_DN_ROOT = 4'd3;
  localparam logic [3:0] S_DN_LAST = 4'd4;
  localparam logic [3:0] S_DN_L    = 4'd5;
  localparam logic [3:0] S_DN_R    = 4'd6;
  localparam logic [3:0] S_DN_PICK = 4'd7;
  localparam logic [3:0] S_DN_CMP  = 4'd8;

  logic [KEY_WIDTH-1:0]     heap_mem [0:CAPACITY];
  logic [KEY_WIDTH-1:0]     rdata;

  logic [3:0]               state;
  logic [CW-1:0]            count;
  logic [FIELD_LIMIT_W-1:0] size_limit;
  logic [CW-1:0]            pos;
  logic [CW:0]              child;
  logic [KEY_WIDTH-1:0]     hold;      // key being inserted or sunk
  logic [KEY_WIDTH-1:0]     cand;      // chosen child during sift down
  logic [KEY_WIDTH-1:0]     kout;      // removed root

  logic                     rd_en;
  logic [CW-1:0]            rd_addr;
  logic                     wr_en;
  logic [CW-1:0]            wr_addr;
  logic [KEY_WIDTH-1:0]     wr_data;

  logic [KEY_WIDTH-1:0]     cmp_a;
  logic [KEY_WIDTH-1:0]     cmp_b;
  logic                     cmp_gt;

  logic                     accept;
  logic                     full;
  logic                     finish;
  logic                     is_remove;
  logic signed [EXTW-1:0]   key_ext;
  logic [EXTW-1:0]          kout_ext;
  logic [CW-1:0]            child_idx;

  assign accept    = start && (state == S_IDLE);
  assign busy      = (state != S_IDLE);
  assign full      = (LW'(count) >= LW'(size_limit)) || (count == CW'(CAPACITY));
  assign key_ext   = EXTW'(cmd.key_in);
  assign kout_ext  = EXTW'(kout);
  assign child_idx = child[CW-1:0];

  // The one shared comparator: signed a > b.
  always_comb begin
    cmp_a = cand;
    cmp_b = hold;
    case (state)
      S_UP_CMP: begin
        cmp_a = hold;
        cmp_b = rdata;
      end
      S_DN_PICK: begin
        cmp_a = rdata;
        cmp_b = cand;
      end
      default: begin
        cmp_a = cand;
        cmp_b = hold;
      end
    endcase
  end

  assign cmp_gt = $signed(cmp_a) > $signed(cmp_b);

  // Memory port steering and the end-of-operation strobe.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = pos;
    wr_data = hold;
    finish  = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept && cmd.func == FUNC_REMOVE && count != '0) begin
          rd_en   = 1'b1;
          rd_addr = CW'(1);
        end
      end
      S_UP_RD: begin
        if (pos == CW'(1)) begin
          wr_en  = 1'b1;
          finish = 1'b1;
        end else begin
          rd_en   = 1'b1;
          rd_addr = pos >> 1;
        end
      end
      S_UP_CMP: begin
        wr_en = 1'b1;
        if (cmp_gt) begin
          wr_data = rdata;
        end else begin
          finish = 1'b1;
        end
      end
      S_DN_ROOT: begin
        rd_en   = 1'b1;
        rd_addr = count + CW'(1);
      end
      S_DN_L: begin
        if (child > {1'b0, count}) begin
          wr_en  = 1'b1;
          finish = 1'b1;
        end else begin
          rd_en   = 1'b1;
          rd_addr = child_idx;
        end
      end
      S_DN_R: begin
        if (child < {1'b0, count}) begin
          rd_en   = 1'b1;
          rd_addr = child_idx + CW'(1);
        end
      end
      S_DN_CMP: begin
        wr_en = 1'b1;
        if (cmp_gt) begin
          wr_data = cand;
        end else begin
          finish = 1'b1;
        end
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      heap_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= heap_mem[rd_addr];
    end
  end

  assign is_remove = (state == S_DN_L) || (state == S_DN_CMP);

  // Sequencer and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      size_limit <= LIMIT_RESET;
      done       <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        size_limit <= cfg_data;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (cmd.func == FUNC_INSERT) begin
              if (full) begin
                done        <= 1'b1;
                res.status  <= ST_FULL;
                res.key_out <= '0;
                res.count   <= FIELD_CNT_W'(count);
              end else begin
                count <= count + CW'(1);
                pos   <= count + CW'(1);
                hold  <= key_ext[KEY_WIDTH-1:0];
                state <= S_UP_RD;
              end
            end else begin
              if (count == '0) begin
                done        <= 1'b1;
                res.status  <= ST_EMPTY;
                res.key_out <= '0;
                res.count   <= FIELD_CNT_W'(count);
              end else begin
                count <= count - CW'(1);
                state <= S_DN_ROOT;
              end
            end
          end
        end
        S_UP_RD: begin
          if (pos != CW'(1)) begin
            state <= S_UP_CMP;
          end
        end
        S_UP_CMP: begin
          if (cmp_gt) begin
            pos   <= pos >> 1;
            state <= S_UP_RD;
          end
        end
        S_DN_ROOT: begin
          kout  <= rdata;
          state <= S_DN_LAST;
        end
        S_DN_LAST: begin
          hold  <= rdata;
          pos   <= CW'(1);
          child <= (CW + 1)'(2);
          state <= S_DN_L;
        end
        S_DN_L: begin
          if (child <= {1'b0, count}) begin
            state <= S_DN_R;
          end
        end
        S_DN_R: begin
          cand <= rdata;
          if (child < {1'b0, count}) begin
            state <= S_DN_PICK;
          end else begin
            state <= S_DN_CMP;
          end
        end
        S_DN_PICK: begin
          // The right child wins only when strictly larger than the left.
          if (cmp_gt) begin
            cand  <= rdata;
            child <= child + (CW + 1)'(1);
          end
          state <= S_DN_CMP;
        end
        S_DN_CMP: begin
          if (cmp_gt) begin
            pos   <= child_idx;
            child <= child << 1;
            state <= S_DN_L;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (finish) begin
        state       <= S_IDLE;
        done        <= 1'b1;
        res.status  <= ST_DONE;
        res.key_out <= is_remove ? $signed(kout_ext[FIELD_KEY_W-1:0]) : '0;
        res.count   <= FIELD_CNT_W'(count);
      end
    end
  end

  // The count never runs past the store.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("key count above capacity");

  // A result beat always lands while the sequencer is idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  // A refused insert leaves the count where it was.
  a_full_keeps: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd.func == FUNC_INSERT && full) |=> (done && count == $past(count)))
    else $error("refused insert changed the count");

  // An empty refusal only happens with nothing held.
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (done && res.status == ST_EMPTY) |-> (count == '0))
    else $error("empty refusal with keys held");

  // Heap position zero is never written.
  a_wr_addr: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (wr_addr != '0))
    else $error("write to heap position zero");

endmodule

/* tb/tb_max_heap_priority_queue.sv */
// Self-checking testbench for the max heap priority queue: directed table plus random beats.
`timescale 1ns / 100ps

module tb_max_heap_priority_queue;
  import mhpq_pkg::*;

  // Depth of the heap under test and the cycle budget for the whole run. The
  // slowest correct run is roughly 2000 beats, each the block's busy time
  // behind a sender gap, well below a tenth of this.
  localparam int HEAP_DEPTH = DEF_CAPACITY;
  localparam int CYCLE_BUDGET = 800000;
  localparam int DRAIN_CYCLES = 40;
  localparam int MAX_REPORTS = 60;

  typedef enum logic {ROW_CMD, ROW_CFG} row_kind_e;

  // One line of the directed table. A command row either carries a result
  // typed in by hand or leaves the expectation to the heap predictor. For a
  // configuration row only the limit field matters.
  typedef struct {
    row_kind_e kind;
    cmd_t      c;
    bit        typed;
    res_t      want;
    logic [FIELD_LIMIT_W-1:0] lim;
  } dir_row_t;

  // One stretch of random traffic under a fixed size limit.
  typedef struct {
    int lim;
    int beats;
    int insert_pct;
  } segment_t;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  cmd_t cmd;
  logic done;
  res_t res;
  logic cfg_we;
  logic [FIELD_LIMIT_W-1:0] cfg_data;

  max_heap_priority_queue uut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .cmd      (cmd),
    .done     (done),
    .res      (res),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  // Shadow of the heap: keys at positions 1..keys_held, the live size limit,
  // and the results that the block still owes, oldest first.
  logic signed [FIELD_KEY_W-1:0] heap_keys [1:HEAP_DEPTH];
  int   keys_held;
  int   limit_shadow;
  res_t due_results [$];

  // Run bookkeeping for the summary and the verdict.
  int fails;
  int cycles;
  int n_insert;
  int n_remove;
  int n_full;
  int n_empty;
  int peak_held;
  int results_seen;

  dir_row_t dir_rows [$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Applies one command to the shadow heap and returns the result the block
  // must report for it. Inserts sift up while strictly greater than the
  // parent; removes pull the last key to the root and sift it down, taking
  // the right child only when it is strictly larger than the left one.
  function automatic res_t apply_heap_op(cmd_t c);
    res_t r;
    int   eff_limit;
    int   slot;
    int   kid;
    logic signed [FIELD_KEY_W-1:0] moved;
    r = '0;
    eff_limit = (limit_shadow < HEAP_DEPTH) ? limit_shadow : HEAP_DEPTH;
    if (c.func == FUNC_INSERT) begin
      n_insert++;
      if (keys_held >= eff_limit) begin
        r.status = ST_FULL;
        n_full++;
      end else begin
        keys_held++;
        slot = keys_held;
        while (slot > 1 && c.key_in > heap_keys[slot / 2]) begin
          heap_keys[slot] = heap_keys[slot / 2];
          slot = slot / 2;
        end
        heap_keys[slot] = c.key_in;
      end
    end else begin
      n_remove++;
      if (keys_held == 0) begin
        r.status = ST_EMPTY;
        n_empty++;
      end else begin
        r.key_out = heap_keys[1];
        moved = heap_keys[keys_held];
        keys_held--;
        slot = 1;
        kid = 2;
        while (kid <= keys_held) begin
          if (kid < keys_held && heap_keys[kid + 1] > heap_keys[kid])
            kid++;
          if (!(heap_keys[kid] > moved))
            break;
          heap_keys[slot] = heap_keys[kid];
          slot = kid;
          kid = kid * 2;
        end
        heap_keys[slot] = moved;
      end
    end
    if (keys_held > peak_held)
      peak_held = keys_held;
    r.count = keys_held[FIELD_CNT_W-1:0];
    return r;
  endfunction

  // Adds a row to the directed table. For a configuration row the last
  // argument is the new limit; for a command row it is the typed count.
  task automatic tab(row_kind_e k, logic f, logic signed [FIELD_KEY_W-1:0] key, bit typed,
                     logic [1:0] st, logic signed [FIELD_KEY_W-1:0] ko,
                     logic [FIELD_CNT_W-1:0] cnt_or_lim);
    dir_row_t row;
    row.kind = k;
    row.c.func = f;
    row.c.key_in = key;
    row.typed = typed;
    row.want.status = st;
    row.want.key_out = ko;
    row.want.count = cnt_or_lim;
    row.lim = cnt_or_lim;
    dir_rows.push_back(row);
  endtask

  // Presents one command beat from a falling edge and holds it until the
  // block takes it. Start is left high on return, so a following beat goes
  // out back to back; whoever idles next lowers it. The expectation is queued
  // in the same step as the acceptance edge.
  task automatic send_cmd(cmd_t c, bit typed, res_t want);
    res_t predicted;
    start = 1'b1;
    cmd = c;
    do @(posedge clk); while (busy);
    predicted = apply_heap_op(c);
    due_results.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  // Writes the size limit only once the block has nothing left in flight.
  // Every beat yields a result and the block is idle in its result cycle, so
  // a short pause after the last result is ample.
  task automatic write_limit(logic [FIELD_LIMIT_W-1:0] v);
    start = 1'b0;
    while (due_results.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we = 1'b1;
    cfg_data = v;
    @(negedge clk);
    cfg_we = 1'b0;
    limit_shadow = v;
  endtask

  // Result checker and cycle watchdog. Outputs are sampled at the rising edge
  // before the block's own updates land, so the comparison sees the beat that
  // was on the result port during the cycle just ending.
  always @(posedge clk) begin
    res_t exp_res;
    cycles++;
    if (!rst && done) begin
      results_seen++;
      if (due_results.size() == 0) begin
        fails++;
        if (fails <= MAX_REPORTS)
          $display("%0t: result beat with nothing outstanding: status %0d key %0d count %0d",
                   $time, res.status, res.key_out, res.count);
      end else begin
        exp_res = due_results.pop_front();
        if (res.status !== exp_res.status) begin
          fails++;
          if (fails <= MAX_REPORTS)
            $display("%0t: status mismatch, expected %0d actual %0d",
                     $time, exp_res.status, res.status);
        end
        if (res.key_out !== exp_res.key_out) begin
          fails++;
          if (fails <= MAX_REPORTS)
            $display("%0t: key_out mismatch, expected %0d actual %0d",
                     $time, exp_res.key_out, res.key_out);
        end
        if (res.count !== exp_res.count) begin
          fails++;
          if (fails <= MAX_REPORTS)
            $display("%0t: count mismatch, expected %0d actual %0d",
                     $time, exp_res.count, res.count);
        end
      end
    end
    if (cycles > CYCLE_BUDGET) begin
      $display("%0t: run exceeded %0d cycles with %0d results outstanding",
               $time, CYCLE_BUDGET, due_results.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    segment_t plan [6];
    int   idle_pct [3];
    int   ph;
    int   sg;
    int   n;
    cmd_t c;
    res_t none;

    start = 1'b0;
    cmd = '0;
    cfg_we = 1'b0;
    cfg_data = '0;
    rst = 1'b1;
    fails = 0;
    cycles = 0;
    keys_held = 0;
    limit_shadow = LIMIT_RESET;
    n_insert = 0;
    n_remove = 0;
    n_full = 0;
    n_empty = 0;
    peak_held = 0;
    results_seen = 0;
    none = '0;

    // Directed table. Results are typed in where they follow directly from
    // the rules: a remove on the empty heap after reset, counts of plain
    // inserts, the largest key coming out first, and refusals under a
    // lowered or zero limit. The rest goes through the predictor.
    tab(ROW_CMD, FUNC_REMOVE, 32'sd77, 1, ST_EMPTY, 0, 0);
    tab(ROW_CMD, FUNC_INSERT, 32'h7FFF_FFFF, 1, ST_DONE, 0, 1);
    tab(ROW_CMD, FUNC_INSERT, 32'h8000_0000, 1, ST_DONE, 0, 2);
    tab(ROW_CMD, FUNC_INSERT, -32'sd1, 1, ST_DONE, 0, 3);
    tab(ROW_CMD, FUNC_INSERT, 32'sd0, 1, ST_DONE, 0, 4);
    tab(ROW_CMD, FUNC_INSERT, 32'sd5, 1, ST_DONE, 0, 5);
    tab(ROW_CMD, FUNC_INSERT, 32'sd5, 1, ST_DONE, 0, 6);
    tab(ROW_CMD, FUNC_REMOVE, -32'sd1, 1, ST_DONE, 32'h7FFF_FFFF, 5);
    tab(ROW_CMD, FUNC_REMOVE, 32'sd0, 0, ST_DONE, 0, 0);
    tab(ROW_CMD, FUNC_REMOVE, 32'sd0, 0, ST_DONE, 0, 0);
    // The limit drops below the number of keys held: an insert is refused,
    // but the held keys can still be removed.
    tab(ROW_CFG, FUNC_INSERT, 0, 0, ST_DONE, 0, 2);
    tab(ROW_CMD, FUNC_INSERT, 32'sd9, 1, ST_FULL, 0, 3);
    tab(ROW_CMD, FUNC_REMOVE, 32'sd0, 0, ST_DONE, 0, 0);
    tab(ROW_CMD, FUNC_REMOVE, 32'sd0, 0, ST_DONE, 0, 0);
    tab(ROW_CMD, FUNC_INSERT, 32'sd3, 0, ST_DONE, 0, 0);
    // A zero limit refuses every insert.
    tab(ROW_CFG, FUNC_INSERT, 0, 0, ST_DONE, 0, 0);
    tab(ROW_CMD, FUNC_INSERT, 32'sd1, 1, ST_FULL, 0, 2);
    tab(ROW_CMD, FUNC_REMOVE, 32'sd0, 0, ST_DONE, 0, 0);
    tab(ROW_CMD, FUNC_REMOVE, 32'sd0, 0, ST_DONE, 0, 0);
    tab(ROW_CMD, FUNC_REMOVE, 32'h8000_0000, 1, ST_EMPTY, 0, 0);
    // A limit above the capacity behaves as the capacity itself.
    tab(ROW_CFG, FUNC_INSERT, 0, 0, ST_DONE, 0, 8'd255);
    tab(ROW_CMD, FUNC_INSERT, 32'h8000_0000, 0, ST_DONE, 0, 0);
    tab(ROW_CMD, FUNC_INSERT, 32'h8000_0000, 0, ST_DONE, 0, 0);
    tab(ROW_CMD, FUNC_REMOVE, 32'sd0, 0, ST_DONE, 0, 0);

    // Random plan, repeated under each idle pattern: fill to capacity with
    // refusals, lower the limit under the held count, drain to empty past
    // the bottom, then churn under tiny and zero limits.
    plan[0] = '{lim: 128, beats: 250, insert_pct: 80};
    plan[1] = '{lim: 100, beats: 80,  insert_pct: 55};
    plan[2] = '{lim: 255, beats: 200, insert_pct: 25};
    plan[3] = '{lim: 7,   beats: 60,  insert_pct: 60};
    plan[4] = '{lim: 0,   beats: 30,  insert_pct: 40};
    plan[5] = '{lim: 1,   beats: 40,  insert_pct: 50};
    idle_pct[0] = 23;
    idle_pct[1] = 85;
    idle_pct[2] = 0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG)
        write_limit(dir_rows[i].lim);
      else
        send_cmd(dir_rows[i].c, dir_rows[i].typed, dir_rows[i].want);
    end

    for (ph = 0; ph < 3; ph++) begin
      for (sg = 0; sg < 6; sg++) begin
        // Each segment starts from a quiet block: the sender waits for every
        // outstanding result before the limit changes.
        write_limit(plan[sg].lim[FIELD_LIMIT_W-1:0]);
        for (n = 0; n < plan[sg].beats; n++) begin
          while ($urandom_range(99) < idle_pct[ph]) begin
            start = 1'b0;
            @(negedge clk);
          end
          c.func = ($urandom_range(99) < plan[sg].insert_pct) ? FUNC_INSERT : FUNC_REMOVE;
          // Full-range keys, a narrow band that forces ties, the extremes, and negative keys.
          case ($urandom_range(9))
            0, 1, 2, 3: c.key_in = $urandom;
            4, 5, 6:    c.key_in = $signed($urandom_range(16)) - 32'sd8;
            7, 8: begin
              case ($urandom_range(3))
                0: c.key_in = 32'h8000_0000;
                1: c.key_in = 32'h7FFF_FFFF;
                2: c.key_in = 32'sd0;
                default: c.key_in = -32'sd1;
              endcase
            end
            default: c.key_in = {1'b1, 31'($urandom)};
          endcase
          send_cmd(c, 0, none);
        end
      end
    end

    start = 1'b0;
    while (due_results.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Covered %0d inserts (%0d refused full) and %0d removes (%0d refused empty).",
             n_insert, n_full, n_remove, n_empty);
    $display("Limits 0 to 255 under three pacing patterns; peak heap size %0d, %0d results.",
             peak_held, results_seen);
    if (fails == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

/* sim.f */
src/mhpq_pkg.sv
src/max_heap_priority_queue.sv
tb/tb_max_heap_priority_queue.sv
